@@ sv/utf16_to_utf8_transcoder_macros.svh @@
// assertion macros shared by the transcoder modules
// depends on nothing; expects clk and rst_n in the including module
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// condition holds at every clock edge outside reset
`define UTT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UTT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/utt_pkg.sv @@
// shared types, constants and byte encoder for the utf-16 to utf-8 transcoder
// depends on nothing
package utt_pkg;

    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;
    localparam logic [5:0]  SURR_HIGH_TAG   = 6'b110110;
    localparam logic [10:0] SUPP_OFFSET     = 11'h040;
    localparam logic [7:0]  LEAD1_MAX       = 8'h7F;
    localparam logic [15:0] LEAD2_MAX       = 16'h07FF;
    localparam logic [7:0]  LEAD2_TAG       = 8'hC0;
    localparam logic [7:0]  LEAD3_TAG       = 8'hE0;
    localparam logic [7:0]  LEAD4_TAG       = 8'hF0;
    localparam logic [7:0]  CONT_TAG        = 8'h80;

    localparam int MAX_BYTES    = 6;
    localparam int CMD_DEPTH_DF = 4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } byte_item_t;

    // one classified item: bytes in send order, byte 0 first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } enc_t;

    // encode one basic-plane value as 1 to 3 bytes
    function automatic enc_t enc16(input logic [15:0] u);
        enc_t e;
        e = '0;
        if (u <= {8'h00, LEAD1_MAX})
        begin
            e.n    = 2'd1;
            e.b[0] = {1'b0, u[6:0]};
        end
        else if (u <= LEAD2_MAX)
        begin
            e.n    = 2'd2;
            e.b[0] = LEAD2_TAG | {3'b000, u[10:6]};
            e.b[1] = CONT_TAG | {2'b00, u[5:0]};
        end
        else
        begin
            e.n    = 2'd3;
            e.b[0] = LEAD3_TAG | {4'h0, u[15:12]};
            e.b[1] = CONT_TAG | {2'b00, u[11:6]};
            e.b[2] = CONT_TAG | {2'b00, u[5:0]};
        end
        return e;
    endfunction

endpackage

@@ sv/utf16_to_utf8_transcoder.sv @@
// utf-16 to utf-8 transcoder: accepted items are queued as byte commands
// throughput one byte per cycle, set by the byte-wide result register while free or popped
// an item gives 0 to 6 bytes; a queue of CMD_DEPTH commands parts the sides
// reset (rst_n, asynchronous, active low) clears held surrogate, queue and result valid bit
// depends on utt_pkg, utt_front, utt_cmd_fifo and utt_back
module utf16_to_utf8_transcoder #(
    parameter int CMD_DEPTH = utt_pkg::CMD_DEPTH_DF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  utt_pkg::unit_item_t unit_data,
    output logic                empty,
    input  logic                pop,
    output utt_pkg::byte_item_t byte_data
);
    import utt_pkg::*;

    // front to queue
    logic       enq;
    cmd_t       cmd;
    // queue to back
    cmd_t       head;
    fifo_stat_t q_stat;
    logic       q_rd;

    // input side stalls only while the command queue is full
    assign full = q_stat.full;

    // front: classify the unit, hold or pair surrogates, build the byte command
    utt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .unit_data (unit_data),
        .q_full    (q_stat.full),
        .enq       (enq),
        .cmd       (cmd)
    );

    // queue lets the front keep taking items while bytes drain
    utt_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (cmd),
        .rd_en   (q_rd),
        .rd_data (head),
        .stat    (q_stat)
    );

    // back: one byte per cycle into the result register while it is free or being popped
    utt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .byte_data (byte_data)
    );

endmodule

@@ sv/utt_front.sv @@
// front part: accepts code units, pairs surrogates, emits byte commands
// depends on utt_pkg
module utt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utt_pkg::unit_item_t unit_data,
    input  logic                q_full,
    output logic                enq,
    output utt_pkg::cmd_t       cmd
);
    import utt_pkg::*;

    logic       high_pending_reg, high_pending_next;
    logic [9:0] high_bits_reg, high_bits_next;
    logic       accept, is_high, is_low, hold_new;
    logic [20:0] cp;
    enc_t       pre_e, post_e;

    assign accept   = push && !q_full;
    assign is_high  = unit_data.code_unit >= SURR_HIGH_FIRST &&
                      unit_data.code_unit <= SURR_HIGH_LAST;
    assign is_low   = unit_data.code_unit >= SURR_LOW_FIRST &&
                      unit_data.code_unit <= SURR_LOW_LAST;
    assign hold_new = is_high && !unit_data.end_of_string;
    assign cp       = {{1'b0, high_bits_reg} + SUPP_OFFSET, unit_data.code_unit[9:0]};

    always_comb
    begin
        pre_e  = enc16({SURR_HIGH_TAG, high_bits_reg});
        post_e = enc16(unit_data.code_unit);
        cmd      = '0;
        cmd.last = unit_data.end_of_string;
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        if (high_pending_reg && is_low)
        begin
            cmd.count    = 3'd4;
            cmd.bytes[0] = LEAD4_TAG | {5'b00000, cp[20:18]};
            cmd.bytes[1] = CONT_TAG | {2'b00, cp[17:12]};
            cmd.bytes[2] = CONT_TAG | {2'b00, cp[11:6]};
            cmd.bytes[3] = CONT_TAG | {2'b00, cp[5:0]};
        end
        else if (high_pending_reg)
        begin
            cmd.bytes[2:0] = pre_e.b;
            if (!hold_new)
            begin
                cmd.bytes[5:3] = post_e.b;
                cmd.count      = 3'd3 + {1'b0, post_e.n};
            end
            else
            begin
                cmd.count = 3'd3;
            end
        end
        else if (!hold_new)
        begin
            cmd.bytes[2:0] = post_e.b;
            cmd.count      = {1'b0, post_e.n};
        end
        if (accept)
        begin
            high_pending_next = hold_new && !(high_pending_reg && is_low);
            high_bits_next    = high_pending_next ? unit_data.code_unit[9:0] : 10'd0;
        end
    end

    // a held high surrogate alone gives no bytes and nothing is queued
    assign enq = accept && (cmd.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= 10'd0;
        end
        else
        begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
        end
    end

endmodule

@@ sv/utt_cmd_fifo.sv @@
// short command queue between the front and back parts
// depends on utt_pkg and the assertion macro header
module utt_cmd_fifo #(
    parameter int DEPTH = utt_pkg::CMD_DEPTH_DF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  utt_pkg::cmd_t       wr_data,
    input  logic                rd_en,
    output utt_pkg::cmd_t       rd_data,
    output utt_pkg::fifo_stat_t stat
);
    import utt_pkg::*;
    `include "utf16_to_utf8_transcoder_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     fill_reg, fill_next;
    logic            do_wr, do_rd;

    assign stat.full  = fill_reg == (AW+1)'(DEPTH);
    assign stat.empty = fill_reg == '0;
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_wr, do_rd})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `UTT_ASSERT_ALWAYS(a_fill_bound, fill_reg <= (AW+1)'(DEPTH), "queue fill above depth")
    `UTT_ASSERT_ALWAYS(a_no_overflow, !(wr_en && stat.full), "write into full queue")
    `UTT_ASSERT_NEXT(a_fill_up, do_wr && !do_rd, fill_reg == $past(fill_reg) + 1'b1, "fill did not rise")

endmodule

@@ sv/utt_back.sv @@
// back part: walks each queued command one byte a cycle into the output register
// when it is free or popped; depends on utt_pkg and the assertion macro header
module utt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  utt_pkg::cmd_t       head,
    input  utt_pkg::fifo_stat_t q_stat,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output utt_pkg::byte_item_t byte_data
);
    import utt_pkg::*;
    `include "utf16_to_utf8_transcoder_macros.svh"

    logic       out_valid_reg, out_valid_next;
    byte_item_t out_reg, out_next;
    logic [2:0] idx_reg, idx_next;
    logic       load, end_of_cmd;

    assign load       = (!out_valid_reg || pop) && !q_stat.empty;
    assign end_of_cmd = idx_reg == head.count - 3'd1;
    assign q_rd       = load && end_of_cmd;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = head.bytes[idx_reg];
            out_next.run_last    = end_of_cmd;
            out_next.string_done = end_of_cmd && head.last;
            idx_next             = end_of_cmd ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty     = !out_valid_reg;
    assign byte_data = out_reg;

    `UTT_ASSERT_ALWAYS(a_idx_in_cmd, q_stat.empty || idx_reg < head.count, "byte index past command")
    `UTT_ASSERT_ALWAYS(a_idx_idle, !q_stat.empty || idx_reg == 3'd0, "index left mid command")
    `UTT_ASSERT_NEXT(a_done_is_last, load && end_of_cmd == 1'b0, !byte_data.string_done, "string done before last byte")

endmodule

@@ sim/tb_utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// testbench for utf16_to_utf8_transcoder: directed and random utf-16 strings, every byte checked
// depends on utt_pkg (item types, surrogate and lead byte constants) and the transcoder rtl
module tb_utf16_to_utf8_transcoder;
    import utt_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RANDOM_GOAL   = 150;   // units sent when the random part stops
    localparam int TAIL_GOAL     = 175;   // units sent when the gap-free tail stops
    localparam int MAX_STR_LEN   = 8;
    localparam int SETTLE_CYCLES = 12;    // margin after the final drain before the verdict

    // what a random unit is drawn from; pairs are a high unit followed by a low unit
    typedef enum int {
        UK_ASCII,
        UK_TWO_BYTE,
        UK_THREE_BYTE,
        UK_HIGH,
        UK_LOW,
        UK_ANY,
        UK_PAIR
    } unit_kind_e;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    unit_item_t unit_data = '0;
    byte_item_t byte_data;

    // predictor state: a held high surrogate and its low ten bits
    bit         held_high = 1'b0;
    logic [9:0] held_bits = '0;

    byte_item_t utf8_expect_q[$];   // bytes still owed by the block, oldest first
    int         mismatches   = 0;
    int         units_sent   = 0;
    int         sink_stall   = 0;
    bit         src_idle_on  = 1'b1;
    bit         sink_idle_on = 1'b1;

    utf16_to_utf8_transcoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .unit_data (unit_data),
        .empty     (empty),
        .pop       (pop),
        .byte_data (byte_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    // generous ceiling: the slowest legal run is well under a tenth of this
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // append the utf-8 bytes of one code point (up to 21 bits)
    function automatic void append_code_point(input logic [20:0] cp, ref logic [7:0] seq[$]);
        if (cp <= 21'h00007F)
            seq.insert(seq.size(), cp[7:0]);
        else if (cp <= 21'h0007FF)
        begin
            seq.insert(seq.size(), LEAD2_TAG | {3'b000, cp[10:6]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[5:0]});
        end
        else if (cp <= 21'h00FFFF)
        begin
            seq.insert(seq.size(), LEAD3_TAG | {4'h0, cp[15:12]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[11:6]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[5:0]});
        end
        else
        begin
            seq.insert(seq.size(), LEAD4_TAG | {5'b00000, cp[20:18]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[17:12]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[11:6]});
            seq.insert(seq.size(), CONT_TAG | {2'b00, cp[5:0]});
        end
    endfunction

    // work out the bytes one accepted unit gives and queue them
    function automatic void predict_utf8(input logic [15:0] cu, input logic eos);
        logic [7:0]  seq[$];
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        byte_item_t  b;
        is_high = (cu >= SURR_HIGH_FIRST) && (cu <= SURR_HIGH_LAST);
        is_low  = (cu >= SURR_LOW_FIRST) && (cu <= SURR_LOW_LAST);
        if (held_high && is_low)
        begin
            // proper pair: one supplementary code point, four bytes
            cp        = 21'h10000 + {1'b0, held_bits, 10'b0} + {5'b0, cu - SURR_LOW_FIRST};
            held_high = 1'b0;
            held_bits = '0;
            append_code_point(cp, seq);
        end
        else
        begin
            // a held high surrogate that does not pair goes out on its own first
            if (held_high)
            begin
                append_code_point({5'b0, SURR_HIGH_FIRST | {6'b0, held_bits}}, seq);
                held_high = 1'b0;
                held_bits = '0;
            end
            if (is_high && !eos)
            begin
                held_high = 1'b1;
                held_bits = cu[9:0];
            end
            else
                append_code_point({5'b0, cu}, seq);
        end
        foreach (seq[k])
        begin
            b.out_byte    = seq[k];
            b.run_last    = (k == seq.size() - 1);
            b.string_done = b.run_last && eos;
            utf8_expect_q.insert(utf8_expect_q.size(), b);
        end
    endfunction

    task automatic check_byte(input byte_item_t got);
        byte_item_t want;
        if (utf8_expect_q.size() == 0)
            report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
        else
        begin
            want = utf8_expect_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte,
                                          want.out_byte));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, want %b on byte %02h", got.run_last,
                                          want.run_last, want.out_byte));
            if (got.string_done !== want.string_done)
                report_mismatch($sformatf("string_done %b, want %b on byte %02h",
                                          got.string_done, want.string_done, want.out_byte));
        end
    endtask

    // result side: every popped byte is checked; pop drops in random stall bursts
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_byte(byte_data);
        if (sink_stall != 0)
            sink_stall = sink_stall - 1;
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
            sink_stall = $urandom_range(1, 5);
        pop <= rst_n && (sink_stall == 0);
    end

    // offer one item and hold it until the block takes it; push stays high afterwards
    // so that the next item can follow on the very next edge
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        push      <= 1'b1;
        unit_data <= '{code_unit: cu, end_of_string: eos};
        @(posedge clk);
        while (full)
            @(posedge clk);
        // accepted at this edge
        predict_utf8(cu, eos);
        units_sent++;
    endtask

    // stop sending and wait until every owed byte has come out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (utf8_expect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_unit(input unit_kind_e kind);
        int unsigned r;
        case (kind)
            UK_ASCII:      r = $urandom_range(16'h0000, 16'h007F);
            UK_TWO_BYTE:   r = $urandom_range(16'h0080, 16'h07FF);
            UK_THREE_BYTE:
            begin
                // basic plane above 0x7ff, skipping the surrogate range
                r = $urandom_range(16'h0800, 16'hF7FF);
                if (r >= SURR_HIGH_FIRST)
                    r = r + 16'h0800;
            end
            UK_HIGH,
            UK_PAIR:       r = $urandom_range(SURR_HIGH_FIRST, SURR_HIGH_LAST);
            UK_LOW:        r = $urandom_range(SURR_LOW_FIRST, SURR_LOW_LAST);
            default:       r = $urandom_range(16'h0000, 16'hFFFF);
        endcase
        return r[15:0];
    endfunction

    // one string of random length; pairs are favoured so the combining path gets most use,
    // while lone surrogates and raw 16-bit values supply the broken sequences
    task automatic send_random_string();
        int          len;
        int          k;
        int unsigned r;
        unit_kind_e  kind;
        len = $urandom_range(1, MAX_STR_LEN);
        k   = 0;
        while (k < len)
        begin
            r    = $urandom_range(0, 9);
            kind = (r <= 5) ? unit_kind_e'(r) : UK_PAIR;
            if (kind == UK_PAIR && k + 1 < len)
            begin
                send_unit(random_unit(UK_HIGH), 1'b0);
                send_unit(random_unit(UK_LOW), k + 2 == len);
                k = k + 2;
            end
            else
            begin
                // a pair with no room left becomes a high surrogate that ends the string
                send_unit(random_unit(kind), k + 1 == len);
                k = k + 1;
            end
        end
    endtask

    // boundaries of every length class, both pairing extremes and each surrogate corner
    task automatic test_directed();
        // one, two and three byte boundaries, either side of the surrogate range
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // lowest and highest pairs; the second ends the string on its low half
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high flushed by a plain ascii unit that ends the string
        send_unit(16'hDA55, 1'b0);
        send_unit(16'h0041, 1'b1);
        // high surrogate as the last unit: goes out at once
        send_unit(16'hDB12, 1'b1);
        // unpaired low surrogates
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high then a three byte unit: six bytes from one item
        send_unit(16'hD800, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // high after high: the first is flushed, the second pairs
        send_unit(16'hD801, 1'b0);
        send_unit(16'hD802, 1'b0);
        send_unit(16'hDC01, 1'b1);
        // held high then a two byte unit at the end of the string
        send_unit(16'hD9AB, 1'b0);
        send_unit(16'h00C5, 1'b1);
        // hold off until the block has caught up
        wait_drained();
    endtask

    // random strings with idling on both sides and the odd full drain
    task automatic test_random_strings();
        while (units_sent < RANDOM_GOAL)
        begin
            send_random_string();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    // last stretch: no gaps from the sender, pop held high
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (units_sent < TAIL_GOAL)
            send_random_string();
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_strings();
        test_back_to_back();

        // every string ends on an end-of-string unit, so nothing is left held
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
